@@ rtl/core/s20_pkg.sv @@
// Package for the Salsa20 stream block: shared types, constants and helpers.
// No dependencies.
`timescale 1ns / 1ps
package s20_pkg;

   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646E;
   localparam logic [31:0] SIGMA2 = 32'h79622D32;
   localparam logic [31:0] SIGMA3 = 32'h6B206574;

   localparam logic [2:0] CSR_KEY01 = 3'd0;
   localparam logic [2:0] CSR_KEY23 = 3'd1;
   localparam logic [2:0] CSR_KEY45 = 3'd2;
   localparam logic [2:0] CSR_KEY67 = 3'd3;
   localparam logic [2:0] CSR_NONCE = 3'd4;

   typedef struct packed {
      logic        start_message;
      logic [31:0] message_word;
      logic [2:0]  valid_bytes;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FEED,
      ST_OUT
   } state_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
      rotl = (v << s) | (v >> (32 - s));
   endfunction

   function automatic logic [3:0] lane(input logic odd, input logic [1:0] q,
                                       input logic [1:0] p);
      logic [3:0] c;
      logic [3:0] r;
      c = {q + p, q};
      r = {q, q + p};
      lane = odd ? r : c;
   endfunction

endpackage

@@ rtl/core/s20_front.sv @@
// Front part: two-entry queue that accepts request beats for the back part.
// Depends on s20_pkg.
`timescale 1ns / 1ps
module s20_front import s20_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  item_type req_item,
   output logic     q_valid,
   input  logic     q_take,
   output item_type q_item
);
   item_type   mem_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic       push;

   assign req_stall = cnt_ff[1];
   assign push = req_valid && !req_stall;
   assign q_valid = cnt_ff != 2'd0;
   assign q_item = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(q_take && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= !wp_ff;
         if (q_take && q_valid) rp_ff <= !rp_ff;
      end
      if (push) mem_ff[wp_ff] <= req_item;
   end

   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue overflow");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> req_stall) else $error("full queue not stalling");
   a_take: assert property (@(posedge clock) disable iff (reset)
      (q_take && q_valid && !push) |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("pop lost");
endmodule

@@ rtl/core/s20_back.sv @@
// Back part: Salsa20 core with one quarter-round per cycle and the XOR stage.
// Depends on s20_pkg.
`timescale 1ns / 1ps
module s20_back import s20_pkg::*; #(
   parameter int ROUNDS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] key01,
   input  logic [63:0] key23,
   input  logic [63:0] key45,
   input  logic [63:0] key67,
   input  logic [63:0] nonce,
   input  logic        q_valid,
   output logic        q_take,
   input  item_type    q_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_cipher_word,
   output logic [2:0]  rsp_out_valid_bytes
);
   localparam int RW = $clog2(ROUNDS + 1);

   state_type   st_ff, st_in;
   logic [31:0] m_ff [16];
   logic [31:0] ks_ff [16];
   logic [63:0] ctr_ff;
   logic [3:0]  pos_ff;
   logic [RW-1:0] rnd_ff;
   logic [1:0]  qr_ff;
   logic [3:0]  fi_ff;
   logic        fresh_ff;
   item_type    it_ff;
   logic        out_v_ff;
   logic [31:0] out_w_ff;
   logic [2:0]  out_b_ff;
   logic [31:0] init [16];
   logic [63:0] ctr_use;
   logic [3:0]  pos_use;
   logic [3:0]  a, b, c, d;
   logic [31:0] nb, nc, nd, na;
   logic [31:0] mask;
   logic        out_free;
   logic        need_blk;
   logic        fire;

   assign ctr_use = it_ff.start_message ? 64'd0 : ctr_ff;
   assign pos_use = it_ff.start_message ? 4'd0 : pos_ff;
   assign out_free = !out_v_ff || !rsp_stall;
   assign need_blk = (pos_use == 4'd0) && !fresh_ff;
   assign fire = (st_ff == ST_OUT) && !need_blk && out_free;

   always_comb begin
      init[0] = SIGMA0;          init[1] = key01[31:0];
      init[2] = key01[63:32];    init[3] = key23[31:0];
      init[4] = key23[63:32];    init[5] = SIGMA1;
      init[6] = nonce[31:0];     init[7] = nonce[63:32];
      init[8] = ctr_use[31:0];   init[9] = ctr_use[63:32];
      init[10] = SIGMA2;         init[11] = key45[31:0];
      init[12] = key45[63:32];   init[13] = key67[31:0];
      init[14] = key67[63:32];   init[15] = SIGMA3;
   end

   always_comb begin
      a = lane(rnd_ff[0], qr_ff, 2'd0);
      b = lane(rnd_ff[0], qr_ff, 2'd1);
      c = lane(rnd_ff[0], qr_ff, 2'd2);
      d = lane(rnd_ff[0], qr_ff, 2'd3);
      nb = m_ff[b] ^ rotl(m_ff[a] + m_ff[d], 7);
      nc = m_ff[c] ^ rotl(nb + m_ff[a], 9);
      nd = m_ff[d] ^ rotl(nc + nb, 13);
      na = m_ff[a] ^ rotl(nd + nc, 18);
   end

   always_comb begin
      unique case (it_ff.valid_bytes)
         3'd0:    mask = 32'h0;
         3'd1:    mask = 32'h0000_00FF;
         3'd2:    mask = 32'h0000_FFFF;
         3'd3:    mask = 32'h00FF_FFFF;
         default: mask = 32'hFFFF_FFFF;
      endcase
   end

   always_comb begin
      st_in = st_ff;
      q_take = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_take = 1'b1;
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (need_blk) st_in = ST_ROUND;
            else if (out_free) st_in = ST_IDLE;
         end
         ST_ROUND: begin
            if (qr_ff == 2'd3 && rnd_ff == RW'(ROUNDS - 1)) st_in = ST_FEED;
         end
         ST_FEED: begin
            if (fi_ff == 4'd15) st_in = ST_OUT;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ctr_ff <= 64'd0;
         pos_ff <= 4'd0;
         out_v_ff <= 1'b0;
         rnd_ff <= '0;
         qr_ff <= 2'd0;
         fi_ff <= 4'd0;
         fresh_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         out_v_ff <= fire || (out_v_ff && rsp_stall);
         if (st_ff == ST_OUT && need_blk) begin
            for (int i = 0; i < 16; i++) m_ff[i] <= init[i];
            rnd_ff <= '0;
            qr_ff <= 2'd0;
            fi_ff <= 4'd0;
            ctr_ff <= ctr_use;
            pos_ff <= 4'd0;
            it_ff.start_message <= 1'b0;
         end
         if (st_ff == ST_ROUND) begin
            m_ff[a] <= na;
            m_ff[b] <= nb;
            m_ff[c] <= nc;
            m_ff[d] <= nd;
            qr_ff <= qr_ff + 2'd1;
            if (qr_ff == 2'd3) rnd_ff <= rnd_ff + RW'(1);
         end
         if (st_ff == ST_FEED) begin
            ks_ff[fi_ff] <= m_ff[fi_ff] + init[fi_ff];
            fi_ff <= fi_ff + 4'd1;
            if (fi_ff == 4'd15) fresh_ff <= 1'b1;
         end
         if (fire) begin
            out_w_ff <= (it_ff.message_word ^ ks_ff[pos_use]) & mask;
            out_b_ff <= it_ff.valid_bytes;
            pos_ff <= pos_use + 4'd1;
            fresh_ff <= 1'b0;
            if (pos_use == 4'd15) ctr_ff <= ctr_ff + 64'd1;
         end
      end
      if (q_take) it_ff <= q_item;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_cipher_word = out_w_ff;
   assign rsp_out_valid_bytes = out_b_ff;
endmodule

@@ rtl/core/salsa20_stream_xor.sv @@
// Top level of the Salsa20 stream XOR block: CSRs, front queue, back core.
// Depends on s20_pkg, s20_front and s20_back.
//
// Channel  Dir  Handshake            Fields
// req_     in   req_valid/req_stall  start_message, message_word, valid_bytes
// rsp_     out  rsp_valid/rsp_stall  cipher_word, out_valid_bytes
// csr_     in   csr_valid/csr_ready  index, data
//
// The back part takes a beat from the queue only once it has issued the last.
// The first beat of each 64-byte block first loads the state, runs the rounds
// one quarter-round at a time and adds the input words back in the feed state.
// Reset is synchronous and clears the keys, nonce, counter and position.
// The request side stalls when the two-entry queue is full, and a stalled
// response holds the back part.
`timescale 1ns / 1ps
module salsa20_stream_xor import s20_pkg::*; #(
   parameter int ROUNDS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_start_message,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_valid_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_cipher_word,
   output logic [2:0]  rsp_out_valid_bytes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   logic [63:0] k01_ff, k23_ff, k45_ff, k67_ff, nonce_ff;
   logic        q_valid, q_take;
   item_type    q_item, req_item;

   assign csr_ready = 1'b1;
   assign req_item = {req_start_message, req_message_word, req_valid_bytes};

   always_ff @(posedge clock) begin
      if (reset) begin
         k01_ff <= '0; k23_ff <= '0; k45_ff <= '0; k67_ff <= '0; nonce_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY01: k01_ff <= csr_data;
            CSR_KEY23: k23_ff <= csr_data;
            CSR_KEY45: k45_ff <= csr_data;
            CSR_KEY67: k67_ff <= csr_data;
            CSR_NONCE: nonce_ff <= csr_data;
            default: ;
         endcase
      end
   end

   s20_front u_front (.*);
   s20_back #(.ROUNDS(ROUNDS)) u_back (
      .clock, .reset, .key01(k01_ff), .key23(k23_ff), .key45(k45_ff), .key67(k67_ff),
      .nonce(nonce_ff), .q_valid, .q_take, .q_item, .rsp_valid, .rsp_stall,
      .rsp_cipher_word, .rsp_out_valid_bytes);
endmodule

@@ tb/sv/salsa20_stream_xor_checker.sv @@
// Checker for the Salsa20 stream XOR block: it watches the CSR, request and
// response channels, predicts each response and compares it.
// Depends on s20_pkg.
`timescale 1ns / 1ps
module salsa20_stream_xor_checker import s20_pkg::*; #(
   parameter int ROUNDS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_start_message,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_cipher_word,
   input  logic [2:0]  rsp_out_valid_bytes,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          errors,
   output int          pending
);

   typedef struct {
      logic [31:0] word;
      logic [2:0]  nbytes;
   } cipher_beat_type;

   cipher_beat_type cipher_q[$];
   logic [63:0] key01, key23, key45, key67, nonce;
   logic [31:0] keystream[16];
   logic [31:0] mix[16];
   logic [63:0] block_num;
   logic [3:0]  word_pos;

   initial begin
      errors = 0;
      pending = 0;
   end

   function automatic logic [31:0] rot_left(input logic [31:0] v, input int s);
      rot_left = (v << s) | (v >> (32 - s));
   endfunction

   task automatic quarter_round(input int a, input int b, input int c, input int d);
      mix[b] = mix[b] ^ rot_left(mix[a] + mix[d], 7);
      mix[c] = mix[c] ^ rot_left(mix[b] + mix[a], 9);
      mix[d] = mix[d] ^ rot_left(mix[c] + mix[b], 13);
      mix[a] = mix[a] ^ rot_left(mix[d] + mix[c], 18);
   endtask

   task automatic build_keystream();
      logic [31:0] init[16];
      init[0] = SIGMA0;
      init[1] = key01[31:0];
      init[2] = key01[63:32];
      init[3] = key23[31:0];
      init[4] = key23[63:32];
      init[5] = SIGMA1;
      init[6] = nonce[31:0];
      init[7] = nonce[63:32];
      init[8] = block_num[31:0];
      init[9] = block_num[63:32];
      init[10] = SIGMA2;
      init[11] = key45[31:0];
      init[12] = key45[63:32];
      init[13] = key67[31:0];
      init[14] = key67[63:32];
      init[15] = SIGMA3;
      for (int i = 0; i < 16; i++) mix[i] = init[i];
      for (int r = 0; r < ROUNDS; r++) begin
         if (r % 2 == 0) begin
            quarter_round(0, 4, 8, 12);
            quarter_round(5, 9, 13, 1);
            quarter_round(10, 14, 2, 6);
            quarter_round(15, 3, 7, 11);
         end else begin
            quarter_round(0, 1, 2, 3);
            quarter_round(5, 6, 7, 4);
            quarter_round(10, 11, 8, 9);
            quarter_round(15, 12, 13, 14);
         end
      end
      for (int i = 0; i < 16; i++) keystream[i] = mix[i] + init[i];
   endtask

   always @(posedge clock) begin
      cipher_beat_type exp_beat;
      logic [31:0] mask;
      if (reset) begin
         key01 <= '0;
         key23 <= '0;
         key45 <= '0;
         key67 <= '0;
         nonce <= '0;
         block_num = '0;
         word_pos = '0;
         cipher_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY01: key01 <= csr_data;
               CSR_KEY23: key23 <= csr_data;
               CSR_KEY45: key45 <= csr_data;
               CSR_KEY67: key67 <= csr_data;
               CSR_NONCE: nonce <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (cipher_q.size() == 0) begin
               $display("%0t: unexpected response beat, actual word %h bytes %0d", $time,
                        rsp_cipher_word, rsp_out_valid_bytes);
               errors++;
            end else begin
               exp_beat = cipher_q.pop_front();
               if (rsp_cipher_word !== exp_beat.word) begin
                  $display("%0t: cipher_word expected %h actual %h", $time, exp_beat.word,
                           rsp_cipher_word);
                  errors++;
               end
               if (rsp_out_valid_bytes !== exp_beat.nbytes) begin
                  $display("%0t: out_valid_bytes expected %0d actual %0d", $time,
                           exp_beat.nbytes, rsp_out_valid_bytes);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_start_message) begin
               block_num = '0;
               word_pos = '0;
            end
            if (word_pos == 0) build_keystream();
            case (req_valid_bytes)
               3'd0: mask = 32'h0;
               3'd1: mask = 32'h0000_00ff;
               3'd2: mask = 32'h0000_ffff;
               3'd3: mask = 32'h00ff_ffff;
               default: mask = 32'hffff_ffff;
            endcase
            exp_beat.word = (req_message_word ^ keystream[word_pos]) & mask;
            exp_beat.nbytes = req_valid_bytes;
            cipher_q.push_back(exp_beat);
            word_pos = word_pos + 4'd1;
            if (word_pos == 0) block_num = block_num + 64'd1;
         end
      end
      pending <= cipher_q.size();
   end

endmodule

@@ tb/sv/tb_salsa20_stream_xor.sv @@
// Testbench top for the Salsa20 stream XOR block: clock, reset, CSR writes,
// request and response traffic, and the verdict.
// Depends on s20_pkg, salsa20_stream_xor and salsa20_stream_xor_checker.
`timescale 1ns / 1ps
module tb_salsa20_stream_xor import s20_pkg::*;;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_start_message = 0;
   logic [31:0] req_message_word = 0;
   logic [2:0]  req_valid_bytes = 3'd4;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [31:0] rsp_cipher_word;
   logic [2:0]  rsp_out_valid_bytes;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_KEY01;
   logic [63:0] csr_data = 0;
   int          errors;
   int          pending;
   int          cycles = 0;
   bit          calm_stall = 0;

   localparam int CYCLE_LIMIT = 1000000;

   always #4 clock = ~clock;

   salsa20_stream_xor uut (.*);

   salsa20_stream_xor_checker chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) calm_stall <= ~calm_stall;
      if (calm_stall) rsp_stall <= 1'b0;
      else if ($urandom_range(0, 99) < 3) rsp_stall <= 1'b1;
      else if (rsp_stall && $urandom_range(0, 99) < 70) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 99) < 20);
   end

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) gap_length = 0;
      else if (pick < 95) gap_length = $urandom_range(1, 3);
      else gap_length = $urandom_range(10, 40);
   endfunction

   task automatic send_word(input logic start, input logic [31:0] word,
                            input logic [2:0] nbytes);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_message <= start;
      req_message_word <= word;
      req_valid_bytes <= nbytes;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_key(input int style);
      logic [63:0] v[5];
      for (int i = 0; i < 5; i++) begin
         if (style == 0) v[i] = '0;
         else if (style == 1) v[i] = '1;
         else v[i] = {$urandom, $urandom};
      end
      write_csr(CSR_KEY01, v[0]);
      write_csr(CSR_KEY23, v[1]);
      write_csr(CSR_KEY45, v[2]);
      write_csr(CSR_KEY67, v[3]);
      write_csr(CSR_NONCE, v[4]);
   endtask

   task automatic random_message(output int len);
      int pick;
      logic [2:0] nb;
      pick = $urandom_range(0, 99);
      if (pick < 70) len = $urandom_range(1, 20);
      else len = $urandom_range(21, 48);
      for (int i = 0; i < len; i++) begin
         nb = 3'd4;
         if (i == len - 1) nb = 3'($urandom_range(1, 4));
         if ($urandom_range(0, 99) < 4) nb = 3'($urandom_range(0, 7));
         send_word((i == 0) ? ($urandom_range(0, 99) < 90) : 1'b0,
                   ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom, nb);
      end
   endtask

   initial begin
      int sent;
      int len;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(1'b1, 32'h0, 3'd4);
      send_word(1'b0, 32'hffff_ffff, 3'd4);
      for (int i = 0; i < 8; i++) send_word(1'b0, 32'hffff_ffff, 3'(i));
      for (int i = 0; i < 10; i++) send_word(1'b0, $urandom, 3'd4);
      send_word(1'b0, 32'ha5a5_a5a5, 3'd2);
      send_word(1'b0, 32'h5a5a_5a5a, 3'd4);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         load_key((phase == 0) ? 1 : 2);
         if (phase == 2) write_csr(CSR_NONCE, 64'h0);
         send_word(1'b1, 32'h0, 3'd4);
         sent = 0;
         while (sent < 400) begin
            random_message(len);
            sent = sent + len;
         end
         drain();
      end

      if (errors == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
